>>> hdl/s256l_pkg.sv
// Shared types, constants and control structures of the sixteen-lane SHA-256 hasher.
// No dependencies; every other file of the block depends on this package.
package s256l_pkg;

    localparam int LANES = 16;
    localparam int LANE_IW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CNT_W = LANE_IW + 2;
    localparam int CFG_IW = 3;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] hash_t;

    localparam logic [CFG_IW-1:0] REG_USE_CUSTOM = 3'd0;
    localparam logic [CFG_IW-1:0] REG_WORDS_0_1 = 3'd1;
    localparam logic [CFG_IW-1:0] REG_WORDS_2_3 = 3'd2;
    localparam logic [CFG_IW-1:0] REG_WORDS_4_5 = 3'd3;
    localparam logic [CFG_IW-1:0] REG_WORDS_6_7 = 3'd4;
    localparam logic [CFG_IW-1:0] REG_PRIOR_BITS = 3'd5;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam hash_t IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam word_t RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic  shift;
        logic  start;
        logic  round;
        logic  add;
        logic  load;
        word_t k;
    } lane_ctl_t;

endpackage

>>> hdl/s256l_if.sv
// Channel interfaces of the hasher: message input, digest output and configuration write.
// Depends on s256l_pkg for the register index width.
interface s256l_msg_if;
    logic        valid;
    logic        ready;
    logic [63:0] lane_bytes_low;
    logic [63:0] lane_bytes_high;
    logic        byte_present;
    logic        finish;

    modport source (output valid, lane_bytes_low, lane_bytes_high, byte_present, finish,
                    input ready);
    modport sink (input valid, lane_bytes_low, lane_bytes_high, byte_present, finish,
                  output ready);
endinterface

interface s256l_digest_if;
    logic        valid;
    logic        ready;
    logic [3:0]  lane_index;
    logic [1:0]  chunk_index;
    logic [63:0] digest_chunk;
    logic        run_last;

    modport source (output valid, lane_index, chunk_index, digest_chunk, run_last,
                    input ready);
    modport sink (input valid, lane_index, chunk_index, digest_chunk, run_last,
                  output ready);
endinterface

interface s256l_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [s256l_pkg::CFG_IW-1:0] index;
    logic [63:0]                  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/s256l_lane.sv
// One SHA-256 lane: 64-byte message window doubling as the schedule, working and chaining words.
// Depends on s256l_pkg for the control structure and the initial hash values.
module s256l_lane (
    input  logic                 clk,
    input  logic                 rst_n,
    input  s256l_pkg::lane_ctl_t ctl,
    input  logic [7:0]           byte_in,
    input  s256l_pkg::hash_t     init,
    output s256l_pkg::hash_t     h
);
    import s256l_pkg::*;

    logic [511:0] win_reg;
    hash_t        v_reg;
    hash_t        h_reg;
    word_t        w0, w1, w9, w14, new_w, t1, t2, s0, s1, e, a;

    function automatic word_t rotr(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb
    begin
        w0 = win_reg[511:480];
        w1 = win_reg[479:448];
        w9 = win_reg[223:192];
        w14 = win_reg[63:32];
        s0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
        s1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
        new_w = w0 + s0 + w9 + s1;
        e = v_reg[4];
        a = v_reg[0];
        t1 = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
             + ((e & v_reg[5]) ^ (~e & v_reg[6])) + ctl.k + w0;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
             + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            win_reg <= {win_reg[503:0], byte_in};
        end
        else if (ctl.round)
        begin
            win_reg <= {win_reg[479:0], new_w};
        end
        if (ctl.start)
        begin
            v_reg <= h_reg;
        end
        else if (ctl.round)
        begin
            v_reg <= {v_reg[6], v_reg[5], v_reg[4], v_reg[3] + t1,
                      v_reg[2], v_reg[1], v_reg[0], t1 + t2};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= IV;
        end
        else if (ctl.load)
        begin
            h_reg <= init;
        end
        else if (ctl.add)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    assign h = h_reg;

endmodule

>>> hdl/sha256_sixteen_lane_hasher_unit.sv
// Top level of the sixteen-lane SHA-256 hasher: control sequencer, lanes and digest output stage.
// Depends on s256l_pkg, the channel interfaces in s256l_if and s256l_lane.
//
// Each message transaction with a byte present shifts one byte into every lane.
// The 64th byte of a block starts the compression, which runs one round per cycle in all
// lanes at once, 64 rounds and then the chaining add, during which no message
// transaction is taken. A finish transaction feeds the padding bytes and the length one per
// cycle, runs one or two further compressions, and then presents the 64 digest chunks, lane 0
// first, at up to one per cycle through a registered output. Configuration writes are taken in
// any cycle, and a write to one of the six defined registers reloads the start state at once.
module sha256_sixteen_lane_hasher_unit (
    input  logic           clk,
    input  logic           rst_n,
    s256l_msg_if.sink      msg,
    s256l_digest_if.source digest,
    s256l_cfg_if.sink      cfg
);
    import s256l_pkg::*;

    state_t           state_reg, state_next;
    logic [5:0]       fill_reg, fill_next;
    logic [63:0]      len_reg, len_next;
    logic [5:0]       rnd_reg, rnd_next;
    logic             first_reg, first_next;
    logic             lenok_reg, lenok_next;
    logic             finp_reg, finp_next;
    logic             pad_reg, pad_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             custom_reg, custom_next;
    logic [3:0][63:0] sw_reg, sw_next;
    logic [63:0]      prior_reg, prior_next;

    logic             out_valid_reg;
    logic [3:0]       out_lane_reg;
    logic [1:0]       out_chunk_reg;
    logic [63:0]      out_data_reg;
    logic             out_last_reg;

    lane_ctl_t        ctl;
    logic             pad_sel;
    logic [7:0]       pad_byte;
    logic             load_out;
    hash_t            init;
    hash_t            lane_h [LANES];
    logic [LANE_IW-1:0] sel_lane;
    logic [1:0]       sel_chunk;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        custom_next = custom_reg;
        sw_next = sw_reg;
        prior_next = prior_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_USE_CUSTOM: custom_next = cfg.data[0];
                REG_WORDS_0_1: sw_next[0] = cfg.data;
                REG_WORDS_2_3: sw_next[1] = cfg.data;
                REG_WORDS_4_5: sw_next[2] = cfg.data;
                REG_WORDS_6_7: sw_next[3] = cfg.data;
                REG_PRIOR_BITS: prior_next = cfg.data;
                default: ;
            endcase
        end
        if (custom_next)
        begin
            for (int i = 0; i < 4; i++)
            begin
                init[2 * i] = sw_next[i][63:32];
                init[2 * i + 1] = sw_next[i][31:0];
            end
        end
        else
        begin
            init = IV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            custom_reg <= 1'b0;
            sw_reg <= '0;
            prior_reg <= '0;
        end
        else
        begin
            custom_reg <= custom_next;
            sw_reg <= sw_next;
            prior_reg <= prior_next;
        end
    end

    assign sel_lane = cnt_reg[CNT_W-1:2];
    assign sel_chunk = cnt_reg[1:0];

    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        len_next = len_reg;
        rnd_next = rnd_reg;
        first_next = first_reg;
        lenok_next = lenok_reg;
        finp_next = finp_reg;
        pad_next = pad_reg;
        cnt_next = cnt_reg;
        ctl = '0;
        ctl.k = RK[rnd_reg];
        pad_sel = 1'b0;
        pad_byte = '0;
        load_out = 1'b0;
        msg.ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                msg.ready = 1'b1;
                if (msg.valid)
                begin
                    if (msg.byte_present)
                    begin
                        ctl.shift = 1'b1;
                        len_next = len_reg + 64'd8;
                        fill_next = fill_reg + 6'd1;
                    end
                    if (msg.byte_present && fill_reg == 6'd63)
                    begin
                        ctl.start = 1'b1;
                        rnd_next = '0;
                        finp_next = msg.finish;
                        state_next = ST_ROUND;
                    end
                    else if (msg.finish)
                    begin
                        pad_next = 1'b1;
                        first_next = 1'b1;
                        lenok_next = 1'b0;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                pad_sel = 1'b1;
                ctl.shift = 1'b1;
                first_next = 1'b0;
                if (first_reg)
                begin
                    pad_byte = PAD_MARK;
                    lenok_next = (fill_reg < 6'd56);
                end
                else if (lenok_reg && fill_reg >= 6'd56)
                begin
                    pad_byte = 8'(len_reg >> {~fill_reg[2:0], 3'b000});
                end
                fill_next = fill_reg + 6'd1;
                if (fill_reg == 6'd63)
                begin
                    ctl.start = 1'b1;
                    rnd_next = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                ctl.round = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                ctl.add = 1'b1;
                if (pad_reg && lenok_reg)
                begin
                    cnt_next = '0;
                    state_next = ST_EMIT;
                end
                else if (pad_reg)
                begin
                    lenok_next = 1'b1;
                    state_next = ST_PAD;
                end
                else if (finp_reg)
                begin
                    finp_next = 1'b0;
                    pad_next = 1'b1;
                    first_next = 1'b1;
                    lenok_next = 1'b0;
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || digest.ready)
                begin
                    load_out = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(LANES * 4 - 1))
                    begin
                        ctl.load = 1'b1;
                        pad_next = 1'b0;
                        fill_next = '0;
                        len_next = custom_next ? prior_next : 64'd0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg.valid && cfg.index <= REG_PRIOR_BITS)
        begin
            ctl.load = 1'b1;
            fill_next = '0;
            len_next = custom_next ? prior_next : 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg <= '0;
            len_reg <= '0;
            rnd_reg <= '0;
            first_reg <= 1'b0;
            lenok_reg <= 1'b0;
            finp_reg <= 1'b0;
            pad_reg <= 1'b0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            len_reg <= len_next;
            rnd_reg <= rnd_next;
            first_reg <= first_next;
            lenok_reg <= lenok_next;
            finp_reg <= finp_next;
            pad_reg <= pad_next;
            cnt_reg <= cnt_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (digest.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_lane_reg <= 4'(sel_lane);
            out_chunk_reg <= sel_chunk;
            out_data_reg <= {lane_h[sel_lane][{sel_chunk, 1'b0}],
                             lane_h[sel_lane][{sel_chunk, 1'b1}]};
            out_last_reg <= (cnt_reg == CNT_W'(LANES * 4 - 1));
        end
    end

    assign digest.valid = out_valid_reg;
    assign digest.lane_index = out_lane_reg;
    assign digest.chunk_index = out_chunk_reg;
    assign digest.digest_chunk = out_data_reg;
    assign digest.run_last = out_last_reg;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic [7:0] data_byte;
        if (l < 8)
        begin : g_low
            assign data_byte = msg.lane_bytes_low[8 * l +: 8];
        end
        else
        begin : g_high
            assign data_byte = msg.lane_bytes_high[8 * (l - 8) +: 8];
        end

        s256l_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .byte_in (pad_sel ? pad_byte : data_byte),
            .init    (init),
            .h       (lane_h[l])
        );
    end

endmodule
